@@ sv/pow_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow_pkg
// shared types, constants and helpers of the premultiplied over/wash blender
// ----------------------------------------------------------------------------
package pow_pkg;

    localparam logic [7:0] CH_MAX   = 8'd255;
    localparam logic [7:0] CH_ROUND = 8'd127;

    // configuration register index
    typedef enum logic [2:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_TOP    = 3'd1,
        CFG_CLIP_WIDTH  = 3'd2,
        CFG_CLIP_HEIGHT = 3'd3,
        CFG_SURF_WIDTH  = 3'd4,
        CFG_SURF_HEIGHT = 3'd5,
        CFG_WASH_LEVEL  = 3'd6,
        CFG_WASH_COLOR  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [12:0]        surf_w;
        logic [12:0]        surf_h;
    } t_clip_cfg;

    // per-item side band traveling down the pipe
    typedef struct packed {
        logic               we;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_tag;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_prod;

    // floor(v / 255) for v below 65280, via (v + v/256 + 1) / 256
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = 17'(v) + 17'(v[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

@@ sv/pow_clip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow_clip
// input stage: clip rectangle, surface and alpha tests, registers the item
// ----------------------------------------------------------------------------
module pow_clip (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  pow_pkg::t_clip_cfg i_cfg,
    input  logic [31:0]        i_src_pixel,
    input  logic [23:0]        i_dst_pixel,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    output logic               o_valid,
    output pow_pkg::t_tag      o_tag,
    output logic [31:0]        o_src,
    output logic [23:0]        o_dst
);

    logic               r_valid;
    pow_pkg::t_tag      r_tag;
    logic [31:0]        r_src;
    logic [23:0]        r_dst;
    logic signed [17:0] n_hi_x;
    logic signed [17:0] n_hi_y;
    logic               n_in_x;
    logic               n_in_y;
    logic               n_we;

    // half-open span [lo, lo+len) computed at full precision, then [0, surf)
    always_comb begin
        n_hi_x = 18'(i_cfg.left) + $signed({2'b00, i_cfg.width});
        n_hi_y = 18'(i_cfg.top) + $signed({2'b00, i_cfg.height});
        n_in_x = (i_pos_x >= i_cfg.left) && (18'(i_pos_x) < n_hi_x) && !i_pos_x[15]
                 && ($unsigned(i_pos_x) < {3'b000, i_cfg.surf_w});
        n_in_y = (i_pos_y >= i_cfg.top) && (18'(i_pos_y) < n_hi_y) && !i_pos_y[15]
                 && ($unsigned(i_pos_y) < {3'b000, i_cfg.surf_h});
        n_we   = n_in_x && n_in_y && (i_src_pixel[31:24] != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= '{we: n_we, x: i_pos_x, y: i_pos_y};
        r_src <= i_src_pixel;
        r_dst <= i_dst_pixel;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_src   = r_src;
    assign o_dst   = r_dst;

endmodule

@@ sv/pow_over.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow_over
// two stages: dst * (255 - alpha) products, then rounded /255, add, saturate
// ----------------------------------------------------------------------------
module pow_over (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pow_pkg::t_tag i_tag,
    input  logic [31:0]   i_src,
    input  logic [23:0]   i_dst,
    output logic          o_valid,
    output pow_pkg::t_tag o_tag,
    output pow_pkg::t_rgb o_rgb
);

    logic [7:0]     n_inv;
    pow_pkg::t_prod n_prod;
    logic           r_valid_p;
    pow_pkg::t_tag  r_tag_p;
    pow_pkg::t_prod r_prod;
    pow_pkg::t_rgb  r_src_p;
    logic [8:0]     n_sum_r;
    logic [8:0]     n_sum_g;
    logic [8:0]     n_sum_b;
    pow_pkg::t_rgb  n_rgb;
    logic           r_valid;
    pow_pkg::t_tag  r_tag;
    pow_pkg::t_rgb  r_rgb;

    // stage a: products with rounding bias
    always_comb begin
        n_inv    = pow_pkg::CH_MAX - i_src[31:24];
        n_prod.r = i_dst[23:16] * n_inv + 16'(pow_pkg::CH_ROUND);
        n_prod.g = i_dst[15:8]  * n_inv + 16'(pow_pkg::CH_ROUND);
        n_prod.b = i_dst[7:0]   * n_inv + 16'(pow_pkg::CH_ROUND);
    end

    // stage b: divide, add source, clamp
    always_comb begin
        n_sum_r = 9'(r_src_p.r) + 9'(pow_pkg::div255(r_prod.r));
        n_sum_g = 9'(r_src_p.g) + 9'(pow_pkg::div255(r_prod.g));
        n_sum_b = 9'(r_src_p.b) + 9'(pow_pkg::div255(r_prod.b));
        n_rgb.r = n_sum_r[8] ? pow_pkg::CH_MAX : n_sum_r[7:0];
        n_rgb.g = n_sum_g[8] ? pow_pkg::CH_MAX : n_sum_g[7:0];
        n_rgb.b = n_sum_b[8] ? pow_pkg::CH_MAX : n_sum_b[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
            r_valid   <= r_valid_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_p <= i_tag;
        r_prod  <= n_prod;
        r_src_p <= i_src[23:0];
        r_tag   <= r_tag_p;
        r_rgb   <= n_rgb;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rgb   = r_rgb;

endmodule

@@ sv/pow_wash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow_wash
// two stages: wash mix products, then truncating /255, bypass and masking
// ----------------------------------------------------------------------------
module pow_wash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pow_pkg::t_tag i_tag,
    input  pow_pkg::t_rgb i_rgb,
    input  logic [7:0]    i_level,
    input  pow_pkg::t_rgb i_wash,
    output logic          o_valid,
    output pow_pkg::t_tag o_tag,
    output logic [23:0]   o_color
);

    logic [7:0]     n_keep;
    pow_pkg::t_prod n_prod;
    logic           r_valid_p;
    pow_pkg::t_tag  r_tag_p;
    pow_pkg::t_prod r_prod;
    pow_pkg::t_rgb  r_rgb_p;
    pow_pkg::t_rgb  n_mix;
    logic [23:0]    n_color;
    logic           r_valid;
    pow_pkg::t_tag  r_tag;
    logic [23:0]    r_color;

    // stage a: c*(255-m) + w*m, at most 255*255
    always_comb begin
        n_keep   = pow_pkg::CH_MAX - i_level;
        n_prod.r = i_rgb.r * n_keep + i_wash.r * i_level;
        n_prod.g = i_rgb.g * n_keep + i_wash.g * i_level;
        n_prod.b = i_rgb.b * n_keep + i_wash.b * i_level;
    end

    // stage b: level zero leaves the over result alone; unwritten pixels read 0
    always_comb begin
        n_mix.r = pow_pkg::div255(r_prod.r);
        n_mix.g = pow_pkg::div255(r_prod.g);
        n_mix.b = pow_pkg::div255(r_prod.b);
        if (!r_tag_p.we) begin
            n_color = 24'd0;
        end else if (i_level == 8'd0) begin
            n_color = r_rgb_p;
        end else begin
            n_color = n_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
            r_valid   <= r_valid_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_p <= i_tag;
        r_prod  <= n_prod;
        r_rgb_p <= i_rgb;
        r_tag   <= r_tag_p;
        r_color <= n_color;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_color = r_color;

endmodule

@@ sv/premultiplied_over_wash_blend.sv @@
`timescale 1ns / 1ps
// a pixel taken at one clock edge passes through the stage registers below in order and then
// appears on the result ports, strobed by o_valid for one cycle
// throughput: one pixel per clock outside reset, start may be held high every cycle
// the five stages are clip test, over products, over divide, wash products, wash divide
// reset (i_rst_n low, synchronous) clears the configuration registers and stage valid bits;
// busy is high only while reset is held, results cannot be held off
// ----------------------------------------------------------------------------
// premultiplied_over_wash_blend
// premultiplied source-over compositing onto an opaque surface, with clip,
// surface bounds, zero alpha rejection and an optional mix toward a wash color
// ----------------------------------------------------------------------------
module premultiplied_over_wash_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_src_pixel,
    input  logic [23:0]        i_dst_pixel,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    // result
    output logic               o_valid,
    output logic               o_write_enable,
    output logic [23:0]        o_out_color,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y
);

    // configuration registers
    pow_pkg::t_clip_cfg r_clip;
    logic [7:0]         r_wash_level;
    pow_pkg::t_rgb      r_wash_color;

    // stage hand-offs
    logic               take;
    logic               clip_valid;
    pow_pkg::t_tag      clip_tag;
    logic [31:0]        clip_src;
    logic [23:0]        clip_dst;
    logic               over_valid;
    pow_pkg::t_tag      over_tag;
    pow_pkg::t_rgb      over_rgb;
    logic               wash_valid;
    pow_pkg::t_tag      wash_tag;
    logic [23:0]        wash_color;

    // the pipe never stalls, so only reset keeps items out
    assign busy = !i_rst_n;
    assign take = start && !busy;

    // register file, all fields reset to zero; the index covers exactly the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip       <= '0;
            r_wash_level <= 8'd0;
            r_wash_color <= '0;
        end else if (i_cfg_we) begin
            case (pow_pkg::t_cfg_idx'(i_cfg_idx))
                pow_pkg::CFG_CLIP_LEFT:   r_clip.left   <= $signed(i_cfg_data[15:0]);
                pow_pkg::CFG_CLIP_TOP:    r_clip.top    <= $signed(i_cfg_data[15:0]);
                pow_pkg::CFG_CLIP_WIDTH:  r_clip.width  <= i_cfg_data[15:0];
                pow_pkg::CFG_CLIP_HEIGHT: r_clip.height <= i_cfg_data[15:0];
                pow_pkg::CFG_SURF_WIDTH:  r_clip.surf_w <= i_cfg_data[12:0];
                pow_pkg::CFG_SURF_HEIGHT: r_clip.surf_h <= i_cfg_data[12:0];
                pow_pkg::CFG_WASH_LEVEL:  r_wash_level  <= i_cfg_data[7:0];
                pow_pkg::CFG_WASH_COLOR:  r_wash_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: bounds and alpha test
    pow_clip u_clip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cfg       (r_clip),
        .i_src_pixel (i_src_pixel),
        .i_dst_pixel (i_dst_pixel),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .o_valid     (clip_valid),
        .o_tag       (clip_tag),
        .o_src       (clip_src),
        .o_dst       (clip_dst)
    );

    // stages 2 and 3: src + round(dst * (255 - a) / 255), clamped
    pow_over u_over (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (clip_valid),
        .i_tag   (clip_tag),
        .i_src   (clip_src),
        .i_dst   (clip_dst),
        .o_valid (over_valid),
        .o_tag   (over_tag),
        .o_rgb   (over_rgb)
    );

    // stages 4 and 5: optional wash mix and final masking
    pow_wash u_wash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (over_valid),
        .i_tag   (over_tag),
        .i_rgb   (over_rgb),
        .i_level (r_wash_level),
        .i_wash  (r_wash_color),
        .o_valid (wash_valid),
        .o_tag   (wash_tag),
        .o_color (wash_color)
    );

    assign o_valid        = wash_valid;
    assign o_write_enable = wash_tag.we;
    assign o_out_color    = wash_color;
    assign o_out_x        = wash_tag.x;
    assign o_out_y        = wash_tag.y;

    // every accepted item comes out on o_valid once it has passed all stage registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##5 o_valid)
        else $error("item did not come out after five cycles");

    // coordinates follow their own item through the pipe
    a_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##5 (o_out_x == $past(i_pos_x, 5) && o_out_y == $past(i_pos_y, 5)))
        else $error("coordinates lost their item");

    // a rejected pixel carries a zero color
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_out_color == 24'd0))
        else $error("unwritten pixel has nonzero color");

    // zero source alpha is never written
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_src_pixel[31:24] == 8'd0) |-> ##5 !o_write_enable)
        else $error("zero alpha pixel was written");

endmodule

@@ tb/sv/premultiplied_over_wash_blend_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// premultiplied_over_wash_blend_tb
// self-checking bench for the over/wash pixel blender: drives pixels through
// the start/busy handshake, predicts every result from a private copy of the
// clip, surface and wash registers, and checks each strobed result in order
// ----------------------------------------------------------------------------

typedef struct packed {
    logic               we;
    logic [23:0]        color;
    logic signed [15:0] x;
    logic signed [15:0] y;
} t_blend_result;

typedef struct {
    int          left;
    int          top;
    int          width;
    int          height;
    int          surf_w;
    int          surf_h;
    int          level;
    logic [23:0] color;
} t_blend_setting;

class blend_scoreboard;
    localparam int CH_FULL     = 255;
    localparam int CH_HALF     = 127;
    localparam int MAX_PRINTED = 100;

    int            clip_left;
    int            clip_top;
    int            clip_width;
    int            clip_height;
    int            surf_w;
    int            surf_h;
    int            wash_level;
    logic [23:0]   wash_color;
    t_blend_result blended_q[$];
    int            errors;

    function new();
        clip_left   = 0;
        clip_top    = 0;
        clip_width  = 0;
        clip_height = 0;
        surf_w      = 0;
        surf_h      = 0;
        wash_level  = 0;
        wash_color  = '0;
        errors      = 0;
    endfunction

    function void write_reg(pow_pkg::t_cfg_idx idx, logic [23:0] data);
        case (idx)
            pow_pkg::CFG_CLIP_LEFT:   clip_left   = int'($signed(data[15:0]));
            pow_pkg::CFG_CLIP_TOP:    clip_top    = int'($signed(data[15:0]));
            pow_pkg::CFG_CLIP_WIDTH:  clip_width  = int'(data[15:0]);
            pow_pkg::CFG_CLIP_HEIGHT: clip_height = int'(data[15:0]);
            pow_pkg::CFG_SURF_WIDTH:  surf_w      = int'(data[12:0]);
            pow_pkg::CFG_SURF_HEIGHT: surf_h      = int'(data[12:0]);
            pow_pkg::CFG_WASH_LEVEL:  wash_level  = int'(data[7:0]);
            pow_pkg::CFG_WASH_COLOR:  wash_color  = data;
            default: ;
        endcase
    endfunction

    // clip span is half open and computed at full precision
    function bit in_span(int p, int lo, int len, int lim);
        return (p >= lo) && (p < lo + len) && (p >= 0) && (p < lim);
    endfunction

    function int over_chan(int s, int d, int inv);
        int v;
        v = s + (d * inv + CH_HALF) / CH_FULL;
        return (v > CH_FULL) ? CH_FULL : v;
    endfunction

    function int wash_chan(int c, int w, int m);
        return (c * (CH_FULL - m) + w * m) / CH_FULL;
    endfunction

    function void note_pixel(logic [31:0] src, logic [23:0] dst,
                             logic signed [15:0] x, logic signed [15:0] y);
        t_blend_result res;
        int            inv;
        int            c;
        int            k;
        res.we = in_span(int'(x), clip_left, clip_width, surf_w) &&
                 in_span(int'(y), clip_top, clip_height, surf_h) &&
                 (src[31:24] != 8'd0);
        res.color = '0;
        res.x     = x;
        res.y     = y;
        if (res.we) begin
            inv = CH_FULL - int'(src[31:24]);
            for (k = 0; k < 3; k++) begin
                c = over_chan(int'(src[8*k +: 8]), int'(dst[8*k +: 8]), inv);
                if (wash_level != 0) begin
                    c = wash_chan(c, int'(wash_color[8*k +: 8]), wash_level);
                end
                res.color[8*k +: 8] = 8'(c);
            end
        end
        blended_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task check_result(t_blend_result got);
        t_blend_result want;
        if (blended_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result we=%0b color=%06h x=%0d y=%0d",
                                      got.we, got.color, got.x, got.y));
        end else begin
            want = blended_q.pop_front();
            if (got.we !== want.we || got.color !== want.color ||
                got.x !== want.x || got.y !== want.y) begin
                report_mismatch($sformatf(
                    "got/want we %0b/%0b color %06h/%06h x %0d/%0d y %0d/%0d",
                    got.we, want.we, got.color, want.color,
                    got.x, want.x, got.y, want.y));
            end
        end
    endtask

    function int pending();
        return blended_q.size();
    endfunction
endclass

module premultiplied_over_wash_blend_tb;

    localparam int PIPE_DEPTH = 5;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        i_src_pixel;
    logic [23:0]        i_dst_pixel;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [23:0]        i_cfg_data;
    logic               o_valid;
    logic               o_write_enable;
    logic [23:0]        o_out_color;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;

    blend_scoreboard sb = new();
    // cleared for one random phase to get a long back-to-back stretch
    bit              idle_on = 1'b1;

    premultiplied_over_wash_blend i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_src_pixel    (i_src_pixel),
        .i_dst_pixel    (i_dst_pixel),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_write_enable (o_write_enable),
        .o_out_color    (o_out_color),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watch both sides at the edge; inputs and outputs change only by
    // nonblocking updates, so the values seen here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(pow_pkg::t_cfg_idx'(i_cfg_idx), i_cfg_data);
            end
            // an item is taken when start is high and busy is low
            if (start && !busy) begin
                sb.note_pixel(i_src_pixel, i_dst_pixel, i_pos_x, i_pos_y);
            end
            // results cannot be held off, so every strobe is a result
            if ($isunknown(o_valid)) begin
                sb.report_mismatch("result strobe unknown");
            end else if (o_valid) begin
                sb.check_result({o_write_enable, o_out_color, o_out_x, o_out_y});
            end
        end
    end

    // present one item and hold it until the block takes it; start stays
    // high on return so back-to-back items need no extra edge
    task automatic send_pixel(input logic [31:0] src, input logic [23:0] dst,
                              input logic signed [15:0] x, input logic signed [15:0] y);
        start       <= 1'b1;
        i_src_pixel <= src;
        i_dst_pixel <= dst;
        i_pos_x     <= x;
        i_pos_y     <= y;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // random sender gap, with junk on the payload while start is low
    task automatic idle_gap();
        int n;
        if (idle_on && $urandom_range(99) < 30) begin
            n = $urandom_range(1, 2);
            start       <= 1'b0;
            i_src_pixel <= $urandom;
            i_dst_pixel <= 24'($urandom);
            i_pos_x     <= 16'($urandom);
            i_pos_y     <= 16'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic pixel(input logic [31:0] src, input logic [23:0] dst,
                         input logic signed [15:0] x, input logic signed [15:0] y);
        send_pixel(src, dst, x, y);
        idle_gap();
    endtask

    // stop sending and wait until every blended item is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input pow_pkg::t_cfg_idx idx, input logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // write all registers; bits above each register's width carry junk
    task automatic apply_setting(input t_blend_setting s);
        cfg_write(pow_pkg::CFG_CLIP_LEFT,   {8'($urandom), 16'(s.left)});
        cfg_write(pow_pkg::CFG_CLIP_TOP,    {8'($urandom), 16'(s.top)});
        cfg_write(pow_pkg::CFG_CLIP_WIDTH,  {8'($urandom), 16'(s.width)});
        cfg_write(pow_pkg::CFG_CLIP_HEIGHT, {8'($urandom), 16'(s.height)});
        cfg_write(pow_pkg::CFG_SURF_WIDTH,  {11'($urandom), 13'(s.surf_w)});
        cfg_write(pow_pkg::CFG_SURF_HEIGHT, {11'($urandom), 13'(s.surf_h)});
        cfg_write(pow_pkg::CFG_WASH_LEVEL,  {16'($urandom), 8'(s.level)});
        cfg_write(pow_pkg::CFG_WASH_COLOR,  s.color);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_blend_setting make_setting(int left, int top, int width, int height,
                                                    int sw, int sh, int level,
                                                    logic [23:0] color);
        t_blend_setting s;
        s.left   = left;
        s.top    = top;
        s.width  = width;
        s.height = height;
        s.surf_w = sw;
        s.surf_h = sh;
        s.level  = level;
        s.color  = color;
        return s;
    endfunction

    function automatic int random_edge();
        case ($urandom_range(9))
            0:       return -32768;
            1:       return 32767;
            default: return int'($urandom_range(80)) - 40;
        endcase
    endfunction

    function automatic int random_span();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 65535;
            default: return int'($urandom_range(160, 1));
        endcase
    endfunction

    // surface sizes above 4096 are legal register values too
    function automatic int random_surface();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 4096;
            2:       return 8191;
            default: return int'($urandom_range(140, 1));
        endcase
    endfunction

    function automatic int random_level();
        case ($urandom_range(9))
            0, 1, 2: return 0;
            3:       return 255;
            4:       return 1;
            default: return int'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed premultiplied pixels, some with channels above alpha
    function automatic logic [31:0] random_src();
        int          a;
        int          k;
        logic [31:0] p;
        case ($urandom_range(9))
            0:       a = 0;
            1:       a = 255;
            default: a = int'($urandom_range(255));
        endcase
        p[31:24] = 8'(a);
        for (k = 0; k < 3; k++) begin
            p[8*k +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(a));
        end
        return p;
    endfunction

    // mostly near the clip and surface, sometimes anywhere in 16 bits
    function automatic logic signed [15:0] random_pos();
        if ($urandom_range(6) == 0) begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(200)) - 30);
    endfunction

    initial begin
        int phase;
        int n;
        start       <= 1'b0;
        i_src_pixel <= '0;
        i_dst_pixel <= '0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= pow_pkg::CFG_CLIP_LEFT;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers give an empty clip, nothing is written
        pixel(32'hFFFFFFFF, 24'hFFFFFF, 16'sd0, 16'sd0);
        pixel(32'h80402010, 24'h123456, 16'sd1, 16'sd1);
        drain_results();

        // clip inside the surface, no wash: edges of the clip rectangle
        apply_setting(make_setting(2, 1, 20, 15, 32, 24, 0, 24'h000000));
        pixel(32'hFF000000, 24'hFFFFFF, 16'sd2, 16'sd1);
        pixel(32'h80402010, 24'hFFFFFF, 16'sd21, 16'sd15);
        pixel(32'hFFFFFFFF, 24'h000000, 16'sd1, 16'sd5);
        pixel(32'hFFFFFFFF, 24'h000000, 16'sd22, 16'sd5);
        pixel(32'hFFFFFFFF, 24'h000000, 16'sd5, 16'sd0);
        pixel(32'hFFFFFFFF, 24'h000000, 16'sd5, 16'sd16);
        // zero alpha inside the clip
        pixel(32'h00FFFFFF, 24'hFFFFFF, 16'sd5, 16'sd5);
        // color above alpha saturates
        pixel(32'h10FFFFFF, 24'h808080, 16'sd6, 16'sd6);
        pixel(32'h01010101, 24'hFFFFFF, 16'sd7, 16'sd7);
        pixel(32'hFFFFFFFF, 24'hFFFFFF, 16'h8000, 16'h7FFF);
        drain_results();

        // full wash, then the weakest wash
        apply_setting(make_setting(2, 1, 20, 15, 32, 24, 255, 24'h123456));
        pixel(32'h80402010, 24'hFFFFFF, 16'sd3, 16'sd3);
        pixel(32'hFFFFFFFF, 24'h000000, 16'sd4, 16'sd4);
        drain_results();
        apply_setting(make_setting(2, 1, 20, 15, 32, 24, 1, 24'hFFFFFF));
        pixel(32'h40102030, 24'h00FF00, 16'sd3, 16'sd3);
        drain_results();

        // surface edge at 4096 with a maximal clip
        apply_setting(make_setting(0, 0, 65535, 65535, 4096, 4096, 128, 24'h00FF00));
        pixel(32'hC0A0B0C0, 24'h0F0F0F, 16'sd4095, 16'sd4095);
        pixel(32'hC0A0B0C0, 24'h0F0F0F, 16'sd4096, 16'sd0);
        drain_results();

        // clip from the most negative edge, surface above 4096
        apply_setting(make_setting(-32768, -32768, 65535, 65535, 8191, 8191, 0, 24'hFFFFFF));
        pixel(32'hFF204060, 24'hABCDEF, 16'sd8190, 16'sd8190);
        pixel(32'hFF204060, 24'hABCDEF, 16'sd8191, 16'sd0);
        pixel(32'hFF204060, 24'hABCDEF, 16'hFFFF, 16'hFFFF);
        drain_results();

        // clip ending exactly at column zero
        apply_setting(make_setting(-10, 0, 10, 1, 8191, 8191, 0, 24'h000000));
        pixel(32'hFFFFFFFF, 24'h000000, 16'sd0, 16'sd0);
        drain_results();

        // random phases, each with its own register setting
        for (phase = 0; phase < 10; phase++) begin
            apply_setting(make_setting(random_edge(), random_edge(), random_span(),
                                       random_span(), random_surface(), random_surface(),
                                       random_level(), 24'($urandom)));
            idle_on = (phase != 4);
            for (n = 0; n < 105; n++) begin
                pixel(random_src(), 24'($urandom), random_pos(), random_pos());
                // let the pipe run dry once in mid phase
                if (phase == 2 && n == 50) begin
                    drain_results();
                end
            end
            drain_results();
        end

        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("premultiplied_over_wash_blend regression: pass");
        end else begin
            $display("premultiplied_over_wash_blend regression: fail");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #200000;
        $display("premultiplied_over_wash_blend regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pow_pkg.sv
sv/pow_clip.sv
sv/pow_over.sv
sv/pow_wash.sv
sv/premultiplied_over_wash_blend.sv
tb/sv/premultiplied_over_wash_blend_tb.sv
